[rtl/core/ils_pkg.sv]
package ils_pkg;

   localparam int CAPACITY = 64;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 32;
   localparam int OP_W     = 3;
   localparam int POS_W    = 7;
   localparam int STAT_W   = 3;

   localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
   localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
   localparam logic [OP_W-1:0] OP_EDIT   = 3'd2;
   localparam logic [OP_W-1:0] OP_DELETE = 3'd3;
   localparam logic [OP_W-1:0] OP_GET    = 3'd4;
   localparam logic [OP_W-1:0] OP_FIND   = 3'd5;

   localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
   localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
   localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd2;
   localparam logic [STAT_W-1:0] ST_BADIDX   = 3'd3;
   localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

   localparam logic [1:0] CELL_HOLD   = 2'd0;
   localparam logic [1:0] CELL_WRITE  = 2'd1;
   localparam logic [1:0] CELL_INSERT = 2'd2;
   localparam logic [1:0] CELL_DELETE = 2'd3;

   localparam logic signed [DATA_W-1:0] NO_DATA = '1;

   typedef struct packed {
      logic [1:0]               kind;
      logic [IDX_W-1:0]         pos;
      logic signed [DATA_W-1:0] value;
   } cell_cmd_type;

   typedef struct packed {
      logic                     valid;
      logic                     is_find;
      logic [IDX_W-1:0]         pos;
      logic [CNT_W-1:0]         limit;
      logic signed [DATA_W-1:0] value;
      logic                     hit;
      logic signed [DATA_W-1:0] data;
      logic [IDX_W-1:0]         fpos;
   } token_type;

   typedef struct packed {
      logic [STAT_W-1:0]        status;
      logic signed [DATA_W-1:0] read_data;
      logic [IDX_W-1:0]         found_position;
      logic                     found;
      logic [CNT_W-1:0]         fill_count;
   } result_type;

endpackage

[rtl/core/ils_cell.sv]
module ils_cell
   import ils_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic [IDX_W-1:0]         cell_index,
   input  cell_cmd_type             cmd,
   input  logic signed [DATA_W-1:0] left_entry,
   input  logic signed [DATA_W-1:0] right_entry,
   output logic signed [DATA_W-1:0] entry,
   input  token_type                tok_in,
   output token_type                tok_out
);

   logic signed [DATA_W-1:0] entry_ff, entry_in;
   token_type                tok_ff, tok_in_next;
   logic                     match;

   always_comb begin
      entry_in = entry_ff;
      case (cmd.kind)
         CELL_WRITE: begin
            if (cell_index == cmd.pos) entry_in = cmd.value;
         end
         CELL_INSERT: begin
            if (cell_index == cmd.pos) entry_in = cmd.value;
            else if (cell_index > cmd.pos) entry_in = left_entry;
         end
         CELL_DELETE: begin
            if (cell_index >= cmd.pos) entry_in = right_entry;
         end
         default: entry_in = entry_ff;
      endcase
   end

   // first hit wins; later cells pass the word on untouched
   always_comb begin
      if (tok_in.is_find)
         match = ({1'b0, cell_index} < tok_in.limit) && (entry_ff == tok_in.value);
      else
         match = (cell_index == tok_in.pos);
      tok_in_next = tok_in;
      if (tok_in.valid && !tok_in.hit && match) begin
         tok_in_next.hit  = 1'b1;
         tok_in_next.data = entry_ff;
         tok_in_next.fpos = cell_index;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in_next;
      end
   end

   assign entry   = entry_ff;
   assign tok_out = tok_ff;

endmodule

[rtl/core/indexed_list_store_core.sv]
// Channel   Direction  Handshake              Word
// req       in         req_valid/req_ready    operation, position, value
// rsp       out        rsp_valid/rsp_ready    status, read_data, found_position,
//                                             found, fill_count, is_empty, is_full
//
// Append, insert, edit and delete act on all cells at once when the word is taken.
// Get and find send a query word along the row of cells, one cell a cycle; the
// word always runs the whole chain, match or not, and no new word is taken meanwhile.
// Rejected operations and unused codes answer without a walk and without touching the cells.
// Synchronous reset empties the list; entries stay undefined until written.
// A word waiting on rsp holds the next result in a pending register.
module indexed_list_store_core
   import ils_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [OP_W-1:0]          req_operation,
   input  logic [POS_W-1:0]         req_position,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [STAT_W-1:0]        rsp_status,
   output logic signed [DATA_W-1:0] rsp_read_data,
   output logic [IDX_W-1:0]         rsp_found_position,
   output logic                     rsp_found,
   output logic [CNT_W-1:0]         rsp_fill_count,
   output logic                     rsp_is_empty,
   output logic                     rsp_is_full
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_WALK = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0]               state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in, count_next;
   logic                     rsp_valid_ff, rsp_valid_in;
   result_type               rsp_ff, rsp_in, pend_ff, pend_in;
   result_type               imm_res, walk_res;
   cell_cmd_type             cmd_w;
   logic                     walk, req_accept, slot_free, is_full, is_empty, pos_ok;
   logic signed [DATA_W-1:0] entry_w [CAPACITY];
   token_type                tok_w [CAPACITY+1];
   token_type                tok_last;

   assign req_ready  = (state_ff == S_IDLE);
   assign req_accept = req_valid && req_ready;
   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign is_full    = (count_ff == CNT_W'(CAPACITY));
   assign is_empty   = (count_ff == '0);
   assign pos_ok     = (req_position < POS_W'(count_ff));

   always_comb begin
      cmd_w.kind  = CELL_HOLD;
      cmd_w.pos   = req_position[IDX_W-1:0];
      cmd_w.value = req_value;
      count_next  = count_ff;
      walk        = 1'b0;
      imm_res.status         = ST_OK;
      imm_res.read_data      = NO_DATA;
      imm_res.found_position = '0;
      imm_res.found          = 1'b0;
      case (req_operation)
         OP_APPEND: begin
            if (is_full) imm_res.status = ST_FULL;
            else begin
               cmd_w.kind = CELL_WRITE;
               cmd_w.pos  = count_ff[IDX_W-1:0];
               count_next = count_ff + 1'b1;
            end
         end
         OP_INSERT: begin
            if (is_full) imm_res.status = ST_FULL;
            else if (req_position > POS_W'(count_ff)) imm_res.status = ST_BADIDX;
            else begin
               cmd_w.kind = CELL_INSERT;
               count_next = count_ff + 1'b1;
            end
         end
         OP_EDIT: begin
            if (!pos_ok) imm_res.status = ST_BADIDX;
            else cmd_w.kind = CELL_WRITE;
         end
         OP_DELETE: begin
            if (is_empty) imm_res.status = ST_EMPTY;
            else if (!pos_ok) imm_res.status = ST_BADIDX;
            else begin
               cmd_w.kind = CELL_DELETE;
               count_next = count_ff - 1'b1;
            end
         end
         OP_GET: begin
            if (!pos_ok) imm_res.status = ST_BADIDX;
            else walk = 1'b1;
         end
         OP_FIND: walk = 1'b1;
         default: imm_res.status = ST_OK;
      endcase
      imm_res.fill_count = count_next;
      // hold the cells unless a word is taken this cycle
      if (!req_accept) begin
         cmd_w.kind = CELL_HOLD;
         count_next = count_ff;
      end
   end

   always_comb begin
      tok_w[0].valid   = req_accept && walk;
      tok_w[0].is_find = (req_operation == OP_FIND);
      tok_w[0].pos     = req_position[IDX_W-1:0];
      tok_w[0].limit   = count_ff;
      tok_w[0].value   = req_value;
      tok_w[0].hit     = 1'b0;
      tok_w[0].data    = NO_DATA;
      tok_w[0].fpos    = '0;
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [DATA_W-1:0] left_w, right_w;
      if (i == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_left
         assign left_w = entry_w[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_w = '0;
      end else begin : g_right
         assign right_w = entry_w[i+1];
      end
      ils_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cell_index  (IDX_W'(i)),
         .cmd         (cmd_w),
         .left_entry  (left_w),
         .right_entry (right_w),
         .entry       (entry_w[i]),
         .tok_in      (tok_w[i]),
         .tok_out     (tok_w[i+1])
      );
   end

   assign tok_last = tok_w[CAPACITY];

   always_comb begin
      walk_res.fill_count = count_ff;
      if (tok_last.is_find) begin
         walk_res.status         = tok_last.hit ? ST_OK : ST_NOTFOUND;
         walk_res.read_data      = NO_DATA;
         walk_res.found_position = tok_last.hit ? tok_last.fpos : '0;
         walk_res.found          = tok_last.hit;
      end else begin
         walk_res.status         = ST_OK;
         walk_res.read_data      = tok_last.data;
         walk_res.found_position = '0;
         walk_res.found          = 1'b0;
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_next;
      rsp_in       = rsp_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (walk) state_in = S_WALK;
               else if (slot_free) begin
                  rsp_in       = imm_res;
                  rsp_valid_in = 1'b1;
               end else begin
                  pend_in  = imm_res;
                  state_in = S_DONE;
               end
            end
         end
         S_WALK: begin
            if (tok_last.valid) begin
               pend_in  = walk_res;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (slot_free) begin
               rsp_in       = pend_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      pend_ff <= pend_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_ff.status;
   assign rsp_read_data      = rsp_ff.read_data;
   assign rsp_found_position = rsp_ff.found_position;
   assign rsp_found          = rsp_ff.found;
   assign rsp_fill_count     = rsp_ff.fill_count;
   assign rsp_is_empty       = (rsp_ff.fill_count == '0);
   assign rsp_is_full        = (rsp_ff.fill_count == CNT_W'(CAPACITY));

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("fill count beyond capacity");

   a_exit_in_walk: assert property (@(posedge clock) disable iff (reset)
      tok_last.valid |-> state_ff == S_WALK)
      else $error("query word left the chain outside a walk");

   a_no_write_in_walk: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WALK |-> cmd_w.kind == CELL_HOLD && count_next == count_ff)
      else $error("cells changed during a walk");

   a_quick_result: assert property (@(posedge clock) disable iff (reset)
      req_accept && !walk && slot_free |=> rsp_valid_ff && state_ff == S_IDLE)
      else $error("single-cycle result not presented");
`endif

endmodule

[verif/tb_indexed_list_store_core.sv]
module tb_indexed_list_store_core;
   import ils_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;
   localparam logic signed [DATA_W-1:0] DATA_MAX = 32'sh7fff_ffff;
   localparam logic signed [DATA_W-1:0] DATA_MIN = 32'sh8000_0000;
   localparam int STALL_LIMIT = 4000;

   typedef struct {
      logic [STAT_W-1:0]        status;
      logic signed [DATA_W-1:0] read_data;
      logic [IDX_W-1:0]         found_position;
      logic                     found;
      logic [CNT_W-1:0]         fill_count;
      logic                     is_empty;
      logic                     is_full;
   } list_answer_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [OP_W-1:0]          req_operation = '0;
   logic [POS_W-1:0]         req_position = '0;
   logic signed [DATA_W-1:0] req_value = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [STAT_W-1:0]        rsp_status;
   logic signed [DATA_W-1:0] rsp_read_data;
   logic [IDX_W-1:0]         rsp_found_position;
   logic                     rsp_found;
   logic [CNT_W-1:0]         rsp_fill_count;
   logic                     rsp_is_empty;
   logic                     rsp_is_full;

   indexed_list_store_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_position       (req_position),
      .req_value          (req_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_read_data      (rsp_read_data),
      .rsp_found_position (rsp_found_position),
      .rsp_found          (rsp_found),
      .rsp_fill_count     (rsp_fill_count),
      .rsp_is_empty       (rsp_is_empty),
      .rsp_is_full        (rsp_is_full)
   );

   always #2 clock = ~clock;

   // shadow copy of the list
   logic signed [DATA_W-1:0] shadow_entries [CAPACITY];
   int                       shadow_count = 0;
   list_answer_type          pending_answers [$];

   int  sender_idle_pct = 0;
   int  receiver_stall_pct = 0;
   int  error_count = 0;
   int  answers_checked = 0;
   int  op_tally [8];
   int  times_full = 0;
   int  times_emptied = 0;
   int  quiet_cycles = 0;
   bit  filling = 1'b1;

   // work out the answer to one accepted word and advance the shadow list
   function automatic void list_apply(input logic [OP_W-1:0] op,
                                      input logic [POS_W-1:0] pos,
                                      input logic signed [DATA_W-1:0] val);
      list_answer_type a;
      int              p;
      p = int'(pos);
      a.status         = ST_OK;
      a.read_data      = NO_DATA;
      a.found_position = '0;
      a.found          = 1'b0;
      op_tally[op]++;
      case (op)
         OP_APPEND: begin
            if (shadow_count >= CAPACITY) begin
               a.status = ST_FULL;
            end else begin
               shadow_entries[shadow_count] = val;
               shadow_count++;
            end
         end
         OP_INSERT: begin
            if (shadow_count >= CAPACITY) begin
               a.status = ST_FULL;
            end else if (p > shadow_count) begin
               a.status = ST_BADIDX;
            end else begin
               for (int i = shadow_count; i > p; i--)
                  shadow_entries[i] = shadow_entries[i-1];
               shadow_entries[p] = val;
               shadow_count++;
            end
         end
         OP_EDIT: begin
            if (p >= shadow_count) a.status = ST_BADIDX;
            else shadow_entries[p] = val;
         end
         OP_DELETE: begin
            if (shadow_count == 0) begin
               a.status = ST_EMPTY;
            end else if (p >= shadow_count) begin
               a.status = ST_BADIDX;
            end else begin
               for (int i = p; i + 1 < shadow_count; i++)
                  shadow_entries[i] = shadow_entries[i+1];
               shadow_count--;
               if (shadow_count == 0) times_emptied++;
            end
         end
         OP_GET: begin
            if (p >= shadow_count) a.status = ST_BADIDX;
            else a.read_data = shadow_entries[p];
         end
         OP_FIND: begin
            a.status = ST_NOTFOUND;
            for (int i = 0; i < shadow_count; i++) begin
               if (shadow_entries[i] == val) begin
                  a.status         = ST_OK;
                  a.found_position = IDX_W'(i);
                  a.found          = 1'b1;
                  break;
               end
            end
         end
         default: begin
         end
      endcase
      if ((op == OP_APPEND || op == OP_INSERT) && a.status == ST_OK
          && shadow_count == CAPACITY)
         times_full++;
      a.fill_count = CNT_W'(shadow_count);
      a.is_empty   = (shadow_count == 0);
      a.is_full    = (shadow_count >= CAPACITY);
      pending_answers.push_back(a);
   endfunction

   task automatic send_word(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                            input logic signed [DATA_W-1:0] val);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_position  <= pos;
      req_value     <= val;
      do @(posedge clock); while (!req_ready);
      list_apply(op, pos, val);
   endtask

   task automatic check_field(input string name, input logic signed [63:0] exp,
                              input logic signed [63:0] act);
      if (exp !== act) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp, act);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      list_answer_type a;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_answers.size() == 0) begin
            $display("%0t: result word with nothing expected, status %0d", $time,
                     rsp_status);
            error_count++;
         end else begin
            a = pending_answers.pop_front();
            answers_checked++;
            check_field("status", a.status, rsp_status);
            check_field("read_data", a.read_data, rsp_read_data);
            check_field("found_position", a.found_position, rsp_found_position);
            check_field("found", a.found, rsp_found);
            check_field("fill_count", a.fill_count, rsp_fill_count);
            check_field("is_empty", a.is_empty, rsp_is_empty);
            check_field("is_full", a.is_full, rsp_is_full);
         end
      end
   end

   // watchdog: no word moving on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: timeout, %0d results outstanding", $time, pending_answers.size());
         $display("tb_indexed_list_store_core NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic signed [DATA_W-1:0] pick_value(input bit from_list);
      int r;
      r = $urandom_range(99);
      if (from_list && shadow_count > 0 && r < 50)
         return shadow_entries[$urandom_range(shadow_count - 1)];
      if (r < 65) return $urandom;
      if (r < 85) return DATA_W'($urandom_range(7));
      case ($urandom_range(3))
         0: return DATA_MAX;
         1: return DATA_MIN;
         2: return '0;
         default: return NO_DATA;
      endcase
   endfunction

   function automatic logic [POS_W-1:0] pick_position(input logic [OP_W-1:0] op);
      int r;
      int span;
      r = $urandom_range(99);
      span = (op == OP_INSERT) ? shadow_count : shadow_count - 1;
      if (r < 80 && span >= 0) return POS_W'($urandom_range(span));
      if (r < 90) return POS_W'(shadow_count);
      return POS_W'($urandom_range(127));
   endfunction

   task automatic random_word();
      logic [OP_W-1:0] op;
      int              r;
      if (shadow_count == CAPACITY) filling = 1'b0;
      if (shadow_count == 0) filling = 1'b1;
      if ($urandom_range(99) < 2) filling = ~filling;
      r = $urandom_range(99);
      if (r < 3) op = $urandom_range(1) ? OP_SPARE6 : OP_SPARE7;
      else if (filling) begin
         if (r < 30) op = OP_APPEND;
         else if (r < 50) op = OP_INSERT;
         else if (r < 60) op = OP_EDIT;
         else if (r < 70) op = OP_DELETE;
         else if (r < 85) op = OP_GET;
         else op = OP_FIND;
      end else begin
         if (r < 10) op = OP_APPEND;
         else if (r < 20) op = OP_INSERT;
         else if (r < 30) op = OP_EDIT;
         else if (r < 60) op = OP_DELETE;
         else if (r < 80) op = OP_GET;
         else op = OP_FIND;
      end
      send_word(op, pick_position(op), pick_value(op == OP_FIND));
   endtask

   // get, delete, edit, find and insert against an empty list
   task automatic test_empty_list();
      send_word(OP_GET, 7'd0, '0);
      send_word(OP_DELETE, 7'd0, '0);
      send_word(OP_EDIT, 7'd0, 32'sd5);
      send_word(OP_FIND, 7'd0, '0);
      send_word(OP_INSERT, 7'd1, 32'sd9);
   endtask

   task automatic test_basic_ops();
      send_word(OP_APPEND, 7'd0, DATA_MAX);
      send_word(OP_APPEND, 7'd127, DATA_MIN);
      send_word(OP_INSERT, 7'd0, NO_DATA);
      send_word(OP_INSERT, 7'd3, '0);
      send_word(OP_INSERT, 7'd127, 32'sd1);
      for (int i = 0; i <= 4; i++) send_word(OP_GET, POS_W'(i), '0);
      send_word(OP_FIND, 7'd0, DATA_MIN);
      send_word(OP_APPEND, 7'd0, NO_DATA);
      send_word(OP_FIND, 7'd0, NO_DATA);
      send_word(OP_FIND, 7'd0, 32'sd12345);
      send_word(OP_EDIT, 7'd1, 32'sd42);
      send_word(OP_EDIT, 7'd5, 32'sd43);
      send_word(OP_DELETE, 7'd127, '0);
      send_word(OP_DELETE, 7'd0, '0);
      send_word(OP_SPARE6, 7'd3, DATA_MAX);
      send_word(OP_SPARE7, 7'd0, '0);
   endtask

   // fill to capacity, hit the full cases, then drain to empty
   task automatic test_full_list();
      while (shadow_count < CAPACITY) begin
         if ($urandom_range(1)) send_word(OP_APPEND, '0, pick_value(1'b0));
         else send_word(OP_INSERT, POS_W'($urandom_range(shadow_count)), pick_value(1'b0));
      end
      send_word(OP_APPEND, '0, 32'sd77);
      send_word(OP_INSERT, 7'd0, 32'sd77);
      send_word(OP_INSERT, 7'd127, 32'sd77);
      send_word(OP_EDIT, 7'd63, 32'sd99);
      send_word(OP_GET, 7'd63, '0);
      send_word(OP_FIND, '0, 32'sd99);
      send_word(OP_GET, 7'd64, '0);
      send_word(OP_DELETE, 7'd64, '0);
      send_word(OP_DELETE, 7'd63, '0);
      while (shadow_count > 0)
         send_word(OP_DELETE, POS_W'($urandom_range(shadow_count - 1)), '0);
      send_word(OP_DELETE, 7'd0, '0);
   endtask

   task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                      input int words);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      repeat (words) random_word();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_list();
      test_basic_ops();
      test_full_list();
      test_random_traffic(0, 0, 160);
      test_random_traffic(52, 0, 160);
      test_random_traffic(0, 52, 160);
      test_random_traffic(23, 23, 160);
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (CAPACITY + 8) @(posedge clock);
      $display("Covered %0d append, %0d insert, %0d edit, %0d delete, %0d get, %0d find, %0d spare",
               op_tally[OP_APPEND], op_tally[OP_INSERT], op_tally[OP_EDIT],
               op_tally[OP_DELETE], op_tally[OP_GET], op_tally[OP_FIND],
               op_tally[OP_SPARE6] + op_tally[OP_SPARE7]);
      $display("List filled %0d times, emptied %0d times, %0d results checked",
               times_full, times_emptied, answers_checked);
      if (error_count == 0 && pending_answers.size() == 0) begin
         $display("tb_indexed_list_store_core OK");
      end else begin
         $display("tb_indexed_list_store_core NOT OK");
      end
      $finish;
   end

endmodule

[indexed_list_store_core.f]
rtl/core/ils_pkg.sv
rtl/core/ils_cell.sv
rtl/core/indexed_list_store_core.sv
verif/tb_indexed_list_store_core.sv
